FILE: rtl/vdh_pkg.sv
// vdh_pkg: types, constants and the fnv-1a byte step shared by the vertex dedup
// hash table modules
// no dependencies
`default_nettype none

package vdh_pkg;

	localparam int TABLE_DEPTH_DEF = 4096;

	localparam int UNIQUE_W = 12;
	localparam int COUNT_W = 13;
	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 13'd4096;

	localparam logic [63:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
	localparam logic [7:0] FNV_PRIME_LO = 8'hB3;

	localparam int HASH_BYTES = 12;
	localparam int MOD_BITS = 4;
	localparam int MOD_STEPS = 64 / MOD_BITS;

	typedef struct packed {
		logic req_type;
		logic [31:0] position_index;
		logic [31:0] texcoord_index;
		logic [31:0] normal_index;
	} vdh_req_t;

	typedef struct packed {
		logic [UNIQUE_W-1:0] unique_index;
		logic was_new;
		logic table_full;
	} vdh_rsp_t;

	typedef struct packed {
		logic clear;
		logic [63:0] tag;
	} vdh_job_t;

	typedef struct packed {
		logic [63:0] tag;
		logic [UNIQUE_W-1:0] uniq;
	} vdh_slot_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_HASH,
		F_MOD,
		F_PUSH
	} vdh_front_state_t;

	typedef enum logic [1:0] {
		B_SWEEP,
		B_IDLE,
		B_CHECK
	} vdh_back_state_t;

	// prime is 2^40 + 2^8 + 0xb3
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + x * {56'd0, FNV_PRIME_LO};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/vdh_front.sv
// vdh_front: takes requests and, for an insert, hashes the index triple one byte per
// cycle and reduces the tag to its home slot four bits per cycle
// depends on vdh_pkg
`default_nettype none

module vdh_front import vdh_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic go,
	input  wire vdh_req_t req,
	output logic busy,
	output logic push_valid,
	input  wire logic push_ready,
	output vdh_job_t job,
	output logic [$clog2(TABLE_DEPTH)-1:0] home_slot
);

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam logic [SW:0] DEPTH_W = (SW+1)'(TABLE_DEPTH);

	vdh_front_state_t state_q, state_d;

	logic clear_q;
	logic [95:0] data_q;
	logic [63:0] h_q;
	logic [63:0] msh_q;
	logic [3:0] bcnt_q;
	logic [3:0] mcnt_q;
	logic [SW-1:0] rem_q;

	logic [63:0] h_nx;
	logic [SW:0] r;
	logic [SW:0] t;
	logic [63:0] sh;
	logic last_byte;

	always_comb begin
		h_nx = fnv_step(h_q, data_q[7:0]);
		last_byte = (bcnt_q == 4'(HASH_BYTES - 1));
		r = {1'b0, rem_q};
		sh = msh_q;
		for (int i = 0; i < MOD_BITS; i++) begin
			t = {r[SW-1:0], sh[63]};
			sh = sh << 1;
			if (t >= DEPTH_W) begin
				t = t - DEPTH_W;
			end
			r = t;
		end
	end

	always_comb begin
		state_d = state_q;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				if (go) begin
					state_d = req.req_type ? F_PUSH : F_HASH;
				end
			end
			F_HASH: begin
				if (last_byte) begin
					state_d = F_MOD;
				end
			end
			F_MOD: begin
				if (mcnt_q == 4'(MOD_STEPS - 1)) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (go) begin
					clear_q <= req.req_type;
					data_q <= {req.normal_index, req.texcoord_index, req.position_index};
					h_q <= FNV_BASIS;
					bcnt_q <= '0;
					rem_q <= '0;
				end
			end
			F_HASH: begin
				// tag is hash plus one
				h_q <= last_byte ? h_nx + 64'd1 : h_nx;
				msh_q <= h_nx + 64'd1;
				data_q <= data_q >> 8;
				bcnt_q <= bcnt_q + 4'd1;
				mcnt_q <= '0;
				rem_q <= '0;
			end
			F_MOD: begin
				rem_q <= r[SW-1:0];
				msh_q <= sh;
				mcnt_q <= mcnt_q + 4'd1;
			end
			F_PUSH: begin
			end
		endcase
	end

	assign busy = (state_q != F_IDLE);
	assign job = '{clear: clear_q, tag: h_q};
	assign home_slot = rem_q;

endmodule

`default_nettype wire

FILE: rtl/vdh_queue.sv
// vdh_queue: two-entry queue between the hashing front and the probing back
// depends on vdh_pkg
`default_nettype none

module vdh_queue import vdh_pkg::*; #(
	parameter int W = $bits(vdh_job_t) + 1
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic push_ready,
	input  wire logic [W-1:0] push_data,
	output logic pop_valid,
	input  wire logic pop,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] ent_q [2];
	logic wptr_q;
	logic rptr_q;
	logic [1:0] cnt_q;
	logic do_push;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_data = ent_q[rptr_q];
	assign do_push = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/vdh_back.sv
// vdh_back: slot memory, sum-of-squares probing, claiming of unique numbers
// and the clearing sweep
// depends on vdh_pkg
`default_nettype none

module vdh_back import vdh_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	output logic pop,
	input  wire vdh_job_t job,
	input  wire logic [$clog2(TABLE_DEPTH)-1:0] home_slot,
	output logic init_busy,
	output logic done,
	output vdh_rsp_t rsp
);

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam logic [SW:0] DEPTH_W = (SW+1)'(TABLE_DEPTH);
	localparam logic [SW-1:0] LAST = SW'(TABLE_DEPTH - 1);

	vdh_back_state_t state_q, state_d;

	vdh_slot_t mem [TABLE_DEPTH];
	vdh_slot_t rd_q;
	vdh_slot_t wr_data;
	logic [SW-1:0] rd_addr;
	logic [SW-1:0] wr_addr;
	logic we;

	logic init_q;
	logic [SW-1:0] sweep_q;
	logic [COUNT_W-1:0] cnt_q;
	logic done_q;
	vdh_rsp_t rsp_q;

	logic [63:0] tag_q;
	logic [SW-1:0] slot_q;
	logic [SW-1:0] sq_q;
	logic [SW-1:0] d_q;
	logic [SW-1:0] k_q;

	logic [SW:0] s_sum, q_sum, d_sum;
	logic [SW-1:0] slot_nx, sq_nx, d_nx;

	logic done_d;
	vdh_rsp_t rsp_d;
	logic claim;
	logic advance;
	logic start_clear;

	always_comb begin
		s_sum = {1'b0, slot_q} + {1'b0, sq_q};
		q_sum = {1'b0, sq_q} + {1'b0, d_q};
		d_sum = {1'b0, d_q} + (SW+1)'(2);
		slot_nx = (s_sum >= DEPTH_W) ? SW'(s_sum - DEPTH_W) : s_sum[SW-1:0];
		sq_nx = (q_sum >= DEPTH_W) ? SW'(q_sum - DEPTH_W) : q_sum[SW-1:0];
		d_nx = (d_sum >= DEPTH_W) ? SW'(d_sum - DEPTH_W) : d_sum[SW-1:0];
	end

	always_comb begin
		state_d = state_q;
		pop = 1'b0;
		we = 1'b0;
		wr_addr = slot_q;
		wr_data = '{tag: tag_q, uniq: cnt_q[UNIQUE_W-1:0]};
		rd_addr = home_slot;
		done_d = 1'b0;
		rsp_d = '0;
		claim = 1'b0;
		advance = 1'b0;
		start_clear = 1'b0;
		unique case (state_q)
			B_SWEEP: begin
				we = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				if (sweep_q == LAST) begin
					state_d = B_IDLE;
				end
			end
			B_IDLE: begin
				if (pop_valid) begin
					pop = 1'b1;
					if (job.clear) begin
						done_d = 1'b1;
						start_clear = 1'b1;
						state_d = B_SWEEP;
					end else begin
						state_d = B_CHECK;
					end
				end
			end
			B_CHECK: begin
				rd_addr = slot_nx;
				priority if (rd_q.tag == 64'd0) begin
					done_d = 1'b1;
					state_d = B_IDLE;
					if (cnt_q[COUNT_W-1]) begin
						rsp_d.table_full = 1'b1;
					end else begin
						we = 1'b1;
						claim = 1'b1;
						rsp_d.unique_index = cnt_q[UNIQUE_W-1:0];
						rsp_d.was_new = 1'b1;
					end
				end else if (rd_q.tag == tag_q) begin
					done_d = 1'b1;
					state_d = B_IDLE;
					rsp_d.unique_index = rd_q.uniq;
				end else if (k_q == LAST) begin
					done_d = 1'b1;
					state_d = B_IDLE;
					rsp_d.table_full = 1'b1;
				end else begin
					advance = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_SWEEP;
			init_q <= 1'b1;
			sweep_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= done_d;
			if (state_q == B_SWEEP) begin
				sweep_q <= sweep_q + SW'(1);
				if (sweep_q == LAST) begin
					init_q <= 1'b0;
				end
			end
			if (start_clear) begin
				sweep_q <= '0;
				cnt_q <= '0;
			end else if (claim) begin
				cnt_q <= cnt_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (pop && !job.clear) begin
			tag_q <= job.tag;
			slot_q <= home_slot;
			sq_q <= '0;
			d_q <= SW'(1);
			k_q <= '0;
		end else if (advance) begin
			slot_q <= slot_nx;
			sq_q <= sq_nx;
			d_q <= d_nx;
			k_q <= k_q + SW'(1);
		end
	end

	assign init_busy = init_q;
	assign done = done_q;
	assign rsp = rsp_q;

	a_new_bumps_count: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && rsp_q.was_new |-> cnt_q == $past(cnt_q) + COUNT_W'(1))
		else $error("new entry without count increment");

	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= COUNT_LIMIT)
		else $error("unique count beyond limit");

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_CHECK |->
			{1'b0, slot_q} < DEPTH_W && {1'b0, sq_q} < DEPTH_W && {1'b0, d_q} < DEPTH_W)
		else $error("probe state out of table range");

	a_rsp_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !(rsp_q.was_new && rsp_q.table_full))
		else $error("result both new and full");

	a_init_sweeps: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> state_q == B_SWEEP)
		else $error("probing before initial sweep finished");

endmodule

`default_nettype wire

FILE: rtl/vertex_dedup_hash_table.sv
// vertex_dedup_hash_table: top level of the vertex triple dedup table
// depends on vdh_pkg, vdh_front, vdh_queue, vdh_back
//
//   channel   handshake           payload
//   request   start / busy        req (vdh_req_t)
//   result    done, one cycle     rsp (vdh_rsp_t)
//
// an insert passes the front in order: byte-serial fnv-1a hash, 4-bit-per-cycle
// slot reduction, transfer (held while the queue is full); a clear only transfers
// the back reads the home slot, then probes slot by slot in a memory with separate
// read and write ports; a clear adds a sweep over all TABLE_DEPTH slots
// after reset the sweep zeroes every slot and busy stays high until it ends
// a two-entry queue lets the front hash the next triple while the back probes
// results are shown for one cycle and cannot be stalled
`default_nettype none

module vertex_dedup_hash_table import vdh_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic busy,
	input  wire vdh_req_t req,
	output logic done,
	output vdh_rsp_t rsp
);

	localparam int SW = $clog2(TABLE_DEPTH);
	localparam int QW = $bits(vdh_job_t) + SW;

	logic go;
	logic front_busy;
	logic init_busy;
	logic push_valid, push_ready;
	logic pop_valid, pop;
	vdh_job_t f_job, b_job;
	logic [SW-1:0] f_slot, b_slot;
	logic [QW-1:0] q_out;

	assign busy = front_busy | init_busy;
	assign go = start & ~busy;

	vdh_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.go(go),
		.req(req),
		.busy(front_busy),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.job(f_job),
		.home_slot(f_slot)
	);

	vdh_queue #(.W(QW)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data({f_job, f_slot}),
		.pop_valid(pop_valid),
		.pop(pop),
		.pop_data(q_out)
	);

	assign b_job = q_out[QW-1:SW];
	assign b_slot = q_out[SW-1:0];

	vdh_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop(pop),
		.job(b_job),
		.home_slot(b_slot),
		.init_busy(init_busy),
		.done(done),
		.rsp(rsp)
	);

endmodule

`default_nettype wire
